// File: src/bit_tick_uart_8n1_core_macros.svh
// Assertion macros shared by the bit-tick UART core.
`ifndef BIT_TICK_UART_8N1_CORE_MACROS_SVH
`define BIT_TICK_UART_8N1_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checks a condition on every clock edge outside reset.
`define BTU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks that a condition in the next cycle follows from the present one.
`define BTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BTU_ASSERT(label, clk, rst, prop, msg)
`define BTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// File: src/btu_pkg.sv
// Types and constants of the bit-tick 8N1 UART core.
package btu_pkg;

   // Number of data bits in one frame; bits above bit 7 are sent as zero.
   localparam int unsigned DATA_BITS = 8;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [2:0] {
      OP_TX_TICK  = 3'd0,
      OP_RX_BIT   = 3'd1,
      OP_RX_START = 3'd2,
      OP_WRITE    = 3'd3,
      OP_SEND     = 3'd4,
      OP_READ     = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_START = 2'd1,
      PH_DATA  = 2'd2,
      PH_STOP  = 2'd3
   } phase_type;

endpackage

// File: src/bit_tick_uart_8n1_core.sv
// Bit-tick 8N1 UART core: transmitter, receiver and host register state.
// Flow: an accepted request is registered in the input stage; its state update and
//    result are captured together in the result register, which holds the response.
// Throughput: one request per clock cycle while the response channel takes results;
//    the UART registers update as the result register captures the result.
// Reset (synchronous, active high): transmitter and receiver idle, TX line high,
//    tx_ready and rx_idle set, all other UART flags and data registers cleared.
`include "bit_tick_uart_8n1_core_macros.svh"

module bit_tick_uart_8n1_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] rx_level, [8:1] tx_byte, [15:9] zero
   input  logic [2:0]  req_tuser,   // [2:0] op
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] tx_line, [8:1] read_data, [9] rx_ready,
                                    // [10] tx_ready, [11] tx_done, [12] rx_idle,
                                    // [13] rx_complete, [15:14] zero
);

   // ------------------------------------------------------------------------
   // Pipeline control. The input stage holds one accepted request; it advances
   // into the UART state and the result register whenever the result register
   // is empty or its transfer completes in the same cycle. The input stage in
   // turn takes a new request when it is empty or advancing, so a request can
   // be accepted every cycle while results drain; a waiting result stalls it once full.
   // ------------------------------------------------------------------------
   logic                   stage_valid_ff, stage_valid_in;
   btu_pkg::op_type        stage_op_ff;
   logic                   stage_level_ff;
   logic [btu_pkg::BYTE_W-1:0] stage_byte_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [btu_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   advance;
   logic                   fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = stage_valid_ff && advance;
   assign req_tready = !stage_valid_ff || advance;

   assign stage_valid_in = (req_tvalid && req_tready) || (stage_valid_ff && !advance);
   assign rsp_valid_in   = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Request payload is captured on every accepted transfer.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_op_ff    <= btu_pkg::op_type'(req_tuser);
         stage_level_ff <= req_tdata[0];
         stage_byte_ff  <= req_tdata[8:1];
      end
   end

   // ------------------------------------------------------------------------
   // UART state.
   // ------------------------------------------------------------------------
   btu_pkg::phase_type tx_phase_ff, tx_phase_in;
   logic [btu_pkg::BYTE_W-1:0]  tx_shift_ff, tx_shift_in;
   logic [btu_pkg::BYTE_W-1:0]  tx_hold_ff, tx_hold_in;
   logic [btu_pkg::COUNT_W-1:0] tx_bit_count_ff, tx_bit_count_in;
   logic                        tx_level_ff, tx_level_in;
   btu_pkg::phase_type rx_phase_ff, rx_phase_in;
   logic [btu_pkg::BYTE_W-1:0]  rx_shift_ff, rx_shift_in;
   logic [btu_pkg::COUNT_W-1:0] rx_bit_count_ff, rx_bit_count_in;
   logic [btu_pkg::BYTE_W-1:0]  rx_hold_ff, rx_hold_in;
   logic tx_ready_ff, tx_ready_in;
   logic tx_done_ff, tx_done_in;
   logic rx_idle_ff, rx_idle_in;
   logic rx_ready_ff, rx_ready_in;
   logic rx_complete_ff, rx_complete_in;

   logic [btu_pkg::COUNT_W-1:0] tx_count_inc;
   logic [btu_pkg::COUNT_W-1:0] rx_count_inc;

   assign tx_count_inc = tx_bit_count_ff + btu_pkg::COUNT_W'(1);
   assign rx_count_inc = rx_bit_count_ff + btu_pkg::COUNT_W'(1);

   // Transmitter next phase. A send restarts the frame from the start bit.
   always_comb begin
      tx_phase_in = tx_phase_ff;
      if (fire) begin
         if (stage_op_ff == btu_pkg::OP_SEND) begin
            tx_phase_in = btu_pkg::PH_START;
         end else if (stage_op_ff == btu_pkg::OP_TX_TICK) begin
            unique case (tx_phase_ff)
               btu_pkg::PH_IDLE:  tx_phase_in = btu_pkg::PH_IDLE;
               btu_pkg::PH_START: tx_phase_in = btu_pkg::PH_DATA;
               btu_pkg::PH_DATA: begin
                  if (tx_count_inc >= btu_pkg::COUNT_W'(btu_pkg::DATA_BITS)) begin
                     tx_phase_in = btu_pkg::PH_STOP;
                  end
               end
               btu_pkg::PH_STOP:  tx_phase_in = btu_pkg::PH_IDLE;
               default:           tx_phase_in = btu_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // Transmitter datapath and host-side transmit flags.
   always_comb begin
      tx_shift_in     = tx_shift_ff;
      tx_hold_in      = tx_hold_ff;
      tx_bit_count_in = tx_bit_count_ff;
      tx_level_in     = tx_level_ff;
      tx_ready_in     = tx_ready_ff;
      tx_done_in      = tx_done_ff;
      if (fire) begin
         unique case (stage_op_ff)
            btu_pkg::OP_TX_TICK: begin
               unique case (tx_phase_ff)
                  btu_pkg::PH_IDLE: begin
                     tx_done_in  = 1'b1;
                     tx_level_in = 1'b1;
                  end
                  btu_pkg::PH_START: tx_level_in = 1'b0;
                  btu_pkg::PH_DATA: begin
                     // Bits beyond the byte go out as zero.
                     if (tx_bit_count_ff < btu_pkg::COUNT_W'(btu_pkg::BYTE_W)) begin
                        tx_level_in = tx_shift_ff[tx_bit_count_ff[2:0]];
                     end else begin
                        tx_level_in = 1'b0;
                     end
                     tx_bit_count_in = tx_count_inc;
                  end
                  btu_pkg::PH_STOP:  tx_level_in = 1'b1;
                  default:           tx_level_in = 1'b1;
               endcase
            end
            btu_pkg::OP_WRITE: begin
               tx_hold_in  = stage_byte_ff;
               tx_ready_in = 1'b0;
            end
            btu_pkg::OP_SEND: begin
               tx_shift_in     = tx_hold_ff;
               tx_hold_in      = '0;
               tx_bit_count_in = '0;
               tx_ready_in     = 1'b1;
               tx_done_in      = 1'b0;
            end
            default: ;
         endcase
      end
   end

   // Receiver next phase. A start check arms it only when idle, the line is
   // low and no completed frame is parked in the shift register.
   always_comb begin
      rx_phase_in = rx_phase_ff;
      if (fire) begin
         if (stage_op_ff == btu_pkg::OP_RX_START) begin
            if (rx_idle_ff && !stage_level_ff && !rx_complete_ff) begin
               rx_phase_in = btu_pkg::PH_START;
            end
         end else if (stage_op_ff == btu_pkg::OP_RX_BIT) begin
            unique case (rx_phase_ff)
               btu_pkg::PH_IDLE:  rx_phase_in = btu_pkg::PH_IDLE;
               btu_pkg::PH_START: begin
                  rx_phase_in = stage_level_ff ? btu_pkg::PH_IDLE : btu_pkg::PH_DATA;
               end
               btu_pkg::PH_DATA: begin
                  if (rx_count_inc >= btu_pkg::COUNT_W'(btu_pkg::DATA_BITS)) begin
                     rx_phase_in = btu_pkg::PH_STOP;
                  end
               end
               btu_pkg::PH_STOP:  rx_phase_in = btu_pkg::PH_IDLE;
               default:           rx_phase_in = btu_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // Receiver datapath and host-side receive flags.
   always_comb begin
      rx_shift_in     = rx_shift_ff;
      rx_bit_count_in = rx_bit_count_ff;
      rx_hold_in      = rx_hold_ff;
      rx_idle_in      = rx_idle_ff;
      rx_ready_in     = rx_ready_ff;
      rx_complete_in  = rx_complete_ff;
      if (fire) begin
         unique case (stage_op_ff)
            btu_pkg::OP_RX_BIT: begin
               unique case (rx_phase_ff)
                  btu_pkg::PH_IDLE: rx_idle_in = 1'b1;
                  btu_pkg::PH_START: begin
                     if (stage_level_ff) begin
                        rx_idle_in = 1'b1;
                     end else begin
                        rx_bit_count_in = '0;
                     end
                  end
                  btu_pkg::PH_DATA: begin
                     // Bits beyond the byte are dropped.
                     if (rx_bit_count_ff < btu_pkg::COUNT_W'(btu_pkg::BYTE_W)) begin
                        rx_shift_in[rx_bit_count_ff[2:0]] = stage_level_ff;
                     end
                     rx_bit_count_in = rx_count_inc;
                  end
                  default: begin
                     // Stop bit: a good one hands the byte over only while a
                     // written transmit byte is pending; a bad one drops it.
                     if (stage_level_ff) begin
                        if (!tx_ready_ff) begin
                           rx_hold_in     = rx_shift_ff;
                           rx_shift_in    = '0;
                           rx_ready_in    = 1'b1;
                           rx_complete_in = 1'b0;
                        end else begin
                           rx_complete_in = 1'b1;
                        end
                     end else begin
                        rx_complete_in = 1'b0;
                        rx_shift_in    = '0;
                     end
                     rx_idle_in = 1'b1;
                  end
               endcase
            end
            btu_pkg::OP_RX_START: begin
               if (rx_idle_ff && !stage_level_ff && !rx_complete_ff) begin
                  rx_idle_in = 1'b0;
               end
            end
            btu_pkg::OP_READ: rx_ready_in = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_phase_ff     <= btu_pkg::PH_IDLE;
         tx_shift_ff     <= '0;
         tx_hold_ff      <= '0;
         tx_bit_count_ff <= '0;
         tx_level_ff     <= 1'b1;
         rx_phase_ff     <= btu_pkg::PH_IDLE;
         rx_shift_ff     <= '0;
         rx_bit_count_ff <= '0;
         rx_hold_ff      <= '0;
         tx_ready_ff     <= 1'b1;
         tx_done_ff      <= 1'b0;
         rx_idle_ff      <= 1'b1;
         rx_ready_ff     <= 1'b0;
         rx_complete_ff  <= 1'b0;
      end else begin
         tx_phase_ff     <= tx_phase_in;
         tx_shift_ff     <= tx_shift_in;
         tx_hold_ff      <= tx_hold_in;
         tx_bit_count_ff <= tx_bit_count_in;
         tx_level_ff     <= tx_level_in;
         rx_phase_ff     <= rx_phase_in;
         rx_shift_ff     <= rx_shift_in;
         rx_bit_count_ff <= rx_bit_count_in;
         rx_hold_ff      <= rx_hold_in;
         tx_ready_ff     <= tx_ready_in;
         tx_done_ff      <= tx_done_in;
         rx_idle_ff      <= rx_idle_in;
         rx_ready_ff     <= rx_ready_in;
         rx_complete_ff  <= rx_complete_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register: the status after the update, captured with the update.
   // ------------------------------------------------------------------------
   assign rsp_data_in = {2'b00, rx_complete_in, rx_idle_in, tx_done_in, tx_ready_in,
                         rx_ready_in, rx_hold_in, tx_level_in};

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `BTU_ASSERT(a_tx_done_only_idle, clock, reset,
      (tx_phase_ff == btu_pkg::PH_IDLE) || !tx_done_ff, "tx_done set during a frame")
   `BTU_ASSERT(a_rx_idle_matches, clock, reset,
      rx_idle_ff == (rx_phase_ff == btu_pkg::PH_IDLE), "rx_idle out of step with rx phase")
   `BTU_ASSERT_NEXT(a_rx_complete_sticky, clock, reset,
      rx_complete_ff, rx_complete_ff, "parked receive frame was released")
   `BTU_ASSERT(a_bit_counts_bounded, clock, reset,
      (tx_bit_count_ff <= btu_pkg::COUNT_W'(btu_pkg::DATA_BITS)) &&
      (rx_bit_count_ff <= btu_pkg::COUNT_W'(btu_pkg::DATA_BITS)), "bit count past frame")

endmodule
